FILE: hdl/lps_pkg.sv
// Shared constants, types and codes for the leading pair selector.
package lps_pkg;

  // Event capacity and curvature cap
  localparam int MAX_CANDIDATES  = 16;
  localparam int CURVATURE_LIMIT = 2047;

  // Curvature to pt: pt = (16 * (BASE + SLOPE*a)) / (DEN * a), clamped
  localparam int CURV_OFFSET   = 9;
  localparam int PT_NUM_BASE   = 327680000;
  localparam int PT_NUM_SLOPE  = 5720;
  localparam int PT_DEN_SLOPE  = 42845;
  localparam int PT_SCALE_SH   = 4;
  localparam int PT_MIN        = 64;
  localparam int PT_MAX        = 16000;

  // Phi wrap, 804 stands for pi
  localparam int PHI_PI     = 804;
  localparam int PHI_TWO_PI = 1608;

  // Field widths
  localparam int PTW   = 16;
  localparam int CURVW = 13;
  localparam int ANGW  = 11;
  localparam int IDXW  = 4;
  localparam int THRW  = 16;

  // Divider datapath: a up to 4095, numerator below 2^33, denominator below 2^28
  localparam int AW    = 12;
  localparam int NW    = 33;
  localparam int DW    = 28;
  localparam int QBITS = 14;
  localparam int WW    = DW + QBITS;

  // Queue between classification and selection, depth a power of two
  localparam int QDEPTH = 32;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);

  // Position counter holds MAX_CANDIDATES itself
  localparam int PW = $clog2(MAX_CANDIDATES + 1);

  typedef enum logic [0:0] {
    CFG_PT_SOURCE  = 1'b0,
    CFG_SEP_THRESH = 1'b1
  } cfg_idx_e;

  // Item as it travels through the pt conversion pipeline
  typedef struct packed {
    logic [PTW-1:0]         cand_pt;
    logic signed [ANGW-1:0] eta;
    logic signed [ANGW-1:0] phi;
    logic                   last;
    logic                   empty;
    logic                   use_curv;
  } meta_t;

  // Classified item held in the queue
  typedef struct packed {
    logic [PTW-1:0]         pt;
    logic signed [ANGW-1:0] eta;
    logic signed [ANGW-1:0] phi;
    logic                   last;
    logic                   empty;
  } cand_t;

  typedef struct packed {
    logic [IDXW-1:0] first_index;
    logic            first_valid;
    logic [IDXW-1:0] second_index;
    logic            second_valid;
    logic            overflow;
  } result_t;

endpackage

FILE: hdl/lps_pt_conv.sv
// Pipelined curvature to pt conversion: product stage, one quotient bit per stage, clamp.
module lps_pt_conv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [lps_pkg::AW-1:0] a_i,
  input  lps_pkg::meta_t       meta_i,
  output logic                 valid_o,
  output lps_pkg::cand_t       data_o
);
  import lps_pkg::*;

  logic            vld_q  [0:QBITS];
  logic [NW-1:0]   rem_q  [0:QBITS];
  logic [DW-1:0]   den_q  [0:QBITS];
  logic [QBITS-1:0] quo_q [0:QBITS];
  logic            sat_q  [0:QBITS];
  meta_t           meta_q [0:QBITS];

  logic [28:0]     num_base;
  logic            out_vld_q;
  cand_t           out_q;
  logic [QBITS-1:0] quo_fin;
  logic [PTW-1:0]  conv_pt;

  assign num_base = 29'(PT_NUM_BASE) + 29'(PT_NUM_SLOPE) * 29'(a_i);

  // Numerator and denominator products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= NW'(num_base) << PT_SCALE_SH;
    den_q[0]  <= DW'(PT_DEN_SLOPE) * DW'(a_i);
    quo_q[0]  <= '0;
    sat_q[0]  <= 1'b0;
    meta_q[0] <= meta_i;
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int B = QBITS - 1 - k;
    logic [WW-1:0] trial;
    logic          ge;
    logic          sat_nx;

    assign trial = WW'(den_q[k]) << B;
    assign ge    = WW'(rem_q[k]) >= trial;

    if (k == 0) begin : g_sat
      // Quotient beyond the bit range saturates to the top clamp
      assign sat_nx = WW'(rem_q[k]) >= (WW'(den_q[k]) << QBITS);
    end else begin : g_nosat
      assign sat_nx = sat_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? NW'(WW'(rem_q[k]) - trial) : rem_q[k];
      den_q[k+1]  <= den_q[k];
      quo_q[k+1]  <= quo_q[k] | (QBITS'(ge) << B);
      sat_q[k+1]  <= sat_nx;
      meta_q[k+1] <= meta_q[k];
    end
  end

  assign quo_fin = quo_q[QBITS];

  always_comb begin
    if (sat_q[QBITS] || (quo_fin > QBITS'(PT_MAX))) begin
      conv_pt = PTW'(PT_MAX);
    end else if (quo_fin < QBITS'(PT_MIN)) begin
      conv_pt = PTW'(PT_MIN);
    end else begin
      conv_pt = PTW'(quo_fin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.pt    <= meta_q[QBITS].use_curv ? conv_pt : meta_q[QBITS].cand_pt;
    out_q.eta   <= meta_q[QBITS].eta;
    out_q.phi   <= meta_q[QBITS].phi;
    out_q.last  <= meta_q[QBITS].last;
    out_q.empty <= meta_q[QBITS].empty;
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

FILE: hdl/lps_front.sv
// Input side: transfer control by queue credits, curvature magnitude, pt conversion.
module lps_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cand_valid_i,
  output logic                            cand_stall_o,
  input  logic [lps_pkg::PTW-1:0]         cand_pt_i,
  input  logic signed [lps_pkg::CURVW-1:0] curvature_i,
  input  logic signed [lps_pkg::ANGW-1:0] cand_eta_i,
  input  logic signed [lps_pkg::ANGW-1:0] cand_phi_i,
  input  logic                            last_candidate_i,
  input  logic                            empty_event_i,
  input  logic                            pt_source_i,
  input  logic                            pop_i,
  output logic                            push_o,
  output lps_pkg::cand_t                  push_data_o
);
  import lps_pkg::*;

  logic              accept;
  logic [CW-1:0]     credits_q, credits_d;
  logic signed [CURVW:0] kk;
  logic [CURVW-1:0]  mag;
  logic [AW-1:0]     a_d, a_q;
  logic              vld_q;
  meta_t             meta_q;

  // Every transfer holds a queue slot until selection pops it
  assign cand_stall_o = (credits_q == CW'(QDEPTH));
  assign accept       = cand_valid_i && !cand_stall_o;

  always_comb begin
    credits_d = credits_q;
    if (accept && !pop_i) begin
      credits_d = credits_q + 1'b1;
    end else if (!accept && pop_i) begin
      credits_d = credits_q - 1'b1;
    end
  end

  always_comb begin
    kk  = {curvature_i[CURVW-1], curvature_i} - (CURVW+1)'(CURV_OFFSET);
    mag = kk[CURVW] ? CURVW'(-kk) : CURVW'(kk);
    if (mag == '0) begin
      mag = CURVW'(1);
    end
    a_d = (mag > CURVW'(CURVATURE_LIMIT)) ? AW'(CURVATURE_LIMIT) : AW'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credits_q <= '0;
      vld_q     <= 1'b0;
    end else begin
      credits_q <= credits_d;
      vld_q     <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q             <= a_d;
      meta_q.cand_pt  <= cand_pt_i;
      meta_q.eta      <= cand_eta_i;
      meta_q.phi      <= cand_phi_i;
      meta_q.last     <= last_candidate_i;
      meta_q.empty    <= empty_event_i;
      meta_q.use_curv <= pt_source_i;
    end
  end

  lps_pt_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q),
    .a_i     (a_q),
    .meta_i  (meta_q),
    .valid_o (push_o),
    .data_o  (push_data_o)
  );

endmodule

FILE: hdl/lps_queue.sv
// Queue of classified candidates between the front and the selection stage.
module lps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lps_pkg::cand_t push_data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output lps_pkg::cand_t data_o
);
  import lps_pkg::*;

  cand_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW-1:0] rd_ptr_d;
  logic [CW-1:0]  count_q;
  cand_t          head_q;

  assign rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;

  // Credits upstream keep pushes within capacity
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    // Load the next head; forward a push that lands on the head slot
    if (push_i && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= push_data_i;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = head_q;

endmodule

FILE: hdl/lps_select.sv
// Greedy leader and separated second selection with the result register.
module lps_select (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  lps_pkg::cand_t          q_data_i,
  output logic                    pop_o,
  input  logic [lps_pkg::THRW-1:0] sep_thresh_i,
  output logic                    res_valid_o,
  input  logic                    res_stall_i,
  output lps_pkg::result_t        res_o
);
  import lps_pkg::*;

  logic [IDXW-1:0]        lead_idx_q, lead_idx_d;
  logic [PTW-1:0]         lead_pt_q, lead_pt_d;
  logic signed [ANGW-1:0] lead_eta_q, lead_eta_d;
  logic signed [ANGW-1:0] lead_phi_q, lead_phi_d;
  logic                   lead_found_q, lead_found_d;
  logic [IDXW-1:0]        sec_idx_q, sec_idx_d;
  logic [PTW-1:0]         sec_pt_q, sec_pt_d;
  logic                   sec_found_q, sec_found_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic                   ovf_q, ovf_d;

  logic                   res_vld_q;
  result_t                res_q, res_d;
  logic                   emit;

  logic signed [ANGW:0]   deta, dphi_raw, dphi;
  logic signed [2*ANGW+1:0] sq_eta, sq_phi;
  logic [2*ANGW+2:0]      dist2;
  logic                   sep;

  // Take an item whenever the result slot is free or drains this cycle
  assign pop_o = q_valid_i && (!res_vld_q || !res_stall_i);

  // Separation from the current leader, phi wrapped into [-pi, pi]
  always_comb begin
    deta     = {q_data_i.eta[ANGW-1], q_data_i.eta} - {lead_eta_q[ANGW-1], lead_eta_q};
    dphi_raw = {q_data_i.phi[ANGW-1], q_data_i.phi} - {lead_phi_q[ANGW-1], lead_phi_q};
    if (dphi_raw > (ANGW+1)'(PHI_PI)) begin
      dphi = dphi_raw - (ANGW+1)'(PHI_TWO_PI);
    end else if (dphi_raw < -(ANGW+1)'(PHI_PI)) begin
      dphi = dphi_raw + (ANGW+1)'(PHI_TWO_PI);
    end else begin
      dphi = dphi_raw;
    end
    sq_eta = deta * deta;
    sq_phi = dphi * dphi;
    dist2  = {1'b0, sq_eta} + {1'b0, sq_phi};
    sep    = dist2 > (2*ANGW+3)'(sep_thresh_i);
  end

  always_comb begin
    lead_idx_d   = lead_idx_q;
    lead_pt_d    = lead_pt_q;
    lead_eta_d   = lead_eta_q;
    lead_phi_d   = lead_phi_q;
    lead_found_d = lead_found_q;
    sec_idx_d    = sec_idx_q;
    sec_pt_d     = sec_pt_q;
    sec_found_d  = sec_found_q;
    pos_d        = pos_q;
    ovf_d        = ovf_q;
    emit         = 1'b0;
    res_d        = '0;

    if (q_data_i.empty) begin
      emit = 1'b1;
    end else begin
      if (pos_q >= PW'(MAX_CANDIDATES)) begin
        ovf_d = 1'b1;
      end else begin
        if (q_data_i.pt > lead_pt_q) begin
          // Old leader drops to second when far enough from the newcomer
          if (lead_found_q && sep) begin
            sec_idx_d   = lead_idx_q;
            sec_pt_d    = lead_pt_q;
            sec_found_d = 1'b1;
          end
          lead_idx_d   = IDXW'(pos_q);
          lead_pt_d    = q_data_i.pt;
          lead_eta_d   = q_data_i.eta;
          lead_phi_d   = q_data_i.phi;
          lead_found_d = 1'b1;
        end else if ((q_data_i.pt > sec_pt_q) && sep) begin
          sec_idx_d   = IDXW'(pos_q);
          sec_pt_d    = q_data_i.pt;
          sec_found_d = 1'b1;
        end
        pos_d = pos_q + 1'b1;
      end

      if (q_data_i.last) begin
        emit = 1'b1;
        if (pos_d == PW'(1)) begin
          res_d.first_valid = 1'b1;
        end else begin
          res_d.first_index  = lead_found_d ? lead_idx_d : '0;
          res_d.first_valid  = lead_found_d;
          res_d.second_index = sec_found_d ? sec_idx_d : '0;
          res_d.second_valid = sec_found_d;
        end
        res_d.overflow = ovf_d;
      end
    end

    // Close the event
    if (emit) begin
      lead_idx_d   = '0;
      lead_pt_d    = '0;
      lead_eta_d   = '0;
      lead_phi_d   = '0;
      lead_found_d = 1'b0;
      sec_idx_d    = '0;
      sec_pt_d     = '0;
      sec_found_d  = 1'b0;
      pos_d        = '0;
      ovf_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_idx_q   <= '0;
      lead_pt_q    <= '0;
      lead_eta_q   <= '0;
      lead_phi_q   <= '0;
      lead_found_q <= 1'b0;
      sec_idx_q    <= '0;
      sec_pt_q     <= '0;
      sec_found_q  <= 1'b0;
      pos_q        <= '0;
      ovf_q        <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        lead_idx_q   <= lead_idx_d;
        lead_pt_q    <= lead_pt_d;
        lead_eta_q   <= lead_eta_d;
        lead_phi_q   <= lead_phi_d;
        lead_found_q <= lead_found_d;
        sec_idx_q    <= sec_idx_d;
        sec_pt_q     <= sec_pt_d;
        sec_found_q  <= sec_found_d;
        pos_q        <= pos_d;
        ovf_q        <= ovf_d;
      end
      if (pop_o && emit) begin
        res_vld_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

FILE: hdl/leading_pair_select_separated_top.sv
// Top level of the leading pair selector with separation cut.
// A result follows the transfer of the event's last candidate through the input register,
//   the 16-stage curvature to pt pipeline, the queue and the result reg.
// Throughput: one candidate per cycle; the 32-entry queue covers the pipeline depth, so the
//   input stalls only while the result output is stalled and the queue fills.
// Reset: asynchronous, active low; clears event state, queue, credits and valid flags,
//   and loads pt_source = 1 and separation_threshold_sq = 5898.
module leading_pair_select_separated_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [lps_pkg::THRW-1:0]         cfg_wdata_i,
  input  logic                             cand_valid_i,
  output logic                             cand_stall_o,
  input  logic [lps_pkg::PTW-1:0]          cand_pt_i,
  input  logic signed [lps_pkg::CURVW-1:0] curvature_i,
  input  logic signed [lps_pkg::ANGW-1:0]  cand_eta_i,
  input  logic signed [lps_pkg::ANGW-1:0]  cand_phi_i,
  input  logic                             last_candidate_i,
  input  logic                             empty_event_i,
  output logic                             res_valid_o,
  input  logic                             res_stall_i,
  output logic [lps_pkg::IDXW-1:0]         first_index_o,
  output logic                             first_valid_o,
  output logic [lps_pkg::IDXW-1:0]         second_index_o,
  output logic                             second_valid_o,
  output logic                             overflow_o
);
  import lps_pkg::*;

  logic            pt_source_q;
  logic [THRW-1:0] sep_thresh_q;
  logic            push, pop, q_valid;
  cand_t           push_data, q_data;
  result_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_source_q  <= 1'b1;
      sep_thresh_q <= THRW'(5898);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PT_SOURCE:  pt_source_q  <= cfg_wdata_i[0];
        CFG_SEP_THRESH: sep_thresh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lps_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cand_valid_i     (cand_valid_i),
    .cand_stall_o     (cand_stall_o),
    .cand_pt_i        (cand_pt_i),
    .curvature_i      (curvature_i),
    .cand_eta_i       (cand_eta_i),
    .cand_phi_i       (cand_phi_i),
    .last_candidate_i (last_candidate_i),
    .empty_event_i    (empty_event_i),
    .pt_source_i      (pt_source_q),
    .pop_i            (pop),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  lps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  lps_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .pop_o        (pop),
    .sep_thresh_i (sep_thresh_q),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .res_o        (res)
  );

  assign first_index_o  = res.first_index;
  assign first_valid_o  = res.first_valid;
  assign second_index_o = res.second_index;
  assign second_valid_o = res.second_valid;
  assign overflow_o     = res.overflow;

endmodule

FILE: hdl/lps_checker.sv
// Port-level checks on the result channel, bound to the top level.
module lps_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     res_valid_o,
  input logic                     res_stall_i,
  input logic [lps_pkg::IDXW-1:0] first_index_o,
  input logic                     first_valid_o,
  input logic [lps_pkg::IDXW-1:0] second_index_o,
  input logic                     second_valid_o,
  input logic                     overflow_o
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> $stable(first_index_o) && $stable(first_valid_o)
      && $stable(second_index_o) && $stable(second_valid_o) && $stable(overflow_o))
    else $error("result payload changed while stalled");

  // An index without its valid bit reads as zero
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (first_valid_o || first_index_o == '0)
      && (second_valid_o || second_index_o == '0))
    else $error("index set without valid bit");

  // A second needs a distinct leader
  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && second_valid_o |-> first_valid_o && (first_index_o != second_index_o))
    else $error("second reported without distinct leader");

endmodule

bind leading_pair_select_separated_top lps_checker u_lps_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the leading pair selector: directed table, then random events.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lps_pkg::*;

  localparam int PHASE_ITEMS  = 67;
  localparam int DRAIN_CYCLES = 24;
  localparam int TAIL_CYCLES  = 40;
  localparam int LONG_HOLD    = 150;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic {ROW_CAND, ROW_REG} row_kind_e;

  typedef struct {
    logic [PTW-1:0]          pt;
    logic signed [CURVW-1:0] curv;
    logic signed [ANGW-1:0]  eta;
    logic signed [ANGW-1:0]  phi;
    logic                    last;
    logic                    empty;
  } cand_item_t;

  typedef struct {
    row_kind_e       kind;
    cand_item_t      item;
    int              reps;
    bit              typed;
    result_t         res;
    cfg_idx_e        reg_idx;
    logic [THRW-1:0] reg_val;
  } stim_row_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic                    cfg_index_i    = 1'b0;
  logic [THRW-1:0]         cfg_wdata_i    = '0;
  logic                    cand_valid_i   = 1'b0;
  logic                    cand_stall_o;
  logic [PTW-1:0]          cand_pt_i      = '0;
  logic signed [CURVW-1:0] curvature_i    = '0;
  logic signed [ANGW-1:0]  cand_eta_i     = '0;
  logic signed [ANGW-1:0]  cand_phi_i     = '0;
  logic                    last_candidate_i = 1'b0;
  logic                    empty_event_i  = 1'b0;
  logic                    res_valid_o;
  logic                    res_stall_i    = 1'b0;
  logic [IDXW-1:0]         first_index_o;
  logic                    first_valid_o;
  logic [IDXW-1:0]         second_index_o;
  logic                    second_valid_o;
  logic                    overflow_o;

  leading_pair_select_separated_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cand_valid_i     (cand_valid_i),
    .cand_stall_o     (cand_stall_o),
    .cand_pt_i        (cand_pt_i),
    .curvature_i      (curvature_i),
    .cand_eta_i       (cand_eta_i),
    .cand_phi_i       (cand_phi_i),
    .last_candidate_i (last_candidate_i),
    .empty_event_i    (empty_event_i),
    .res_valid_o      (res_valid_o),
    .res_stall_i      (res_stall_i),
    .first_index_o    (first_index_o),
    .first_valid_o    (first_valid_o),
    .second_index_o   (second_index_o),
    .second_valid_o   (second_valid_o),
    .overflow_o       (overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow registers and event state of the selection predictor
  logic            cfg_src = 1'b1;
  logic [THRW-1:0] cfg_thr = 16'd5898;
  int              ev_lead_idx, ev_lead_eta, ev_lead_phi, ev_sec_idx, ev_count;
  int unsigned     ev_lead_pt, ev_sec_pt;
  bit              ev_lead_found, ev_sec_found, ev_over;

  result_t         sel_expected_q[$];
  stim_row_t       dir_table[$];

  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;
  int base_eta, base_phi;
  int n_fail, n_transfers, n_checked, n_second, n_overflow, n_reg_writes, n_cycles;

  function automatic int unsigned curv_pt(input logic signed [CURVW-1:0] curv);
    int    k;
    longint a, q;
    k = int'(curv) - CURV_OFFSET;
    if (k == 0) k = 1;
    a = (k < 0) ? -k : k;
    if (a > CURVATURE_LIMIT) a = CURVATURE_LIMIT;
    q = (16 * (longint'(PT_NUM_BASE) + longint'(PT_NUM_SLOPE) * a)) /
        (longint'(PT_DEN_SLOPE) * a);
    if (q > PT_MAX) q = PT_MAX;
    if (q < PT_MIN) q = PT_MIN;
    return q[31:0];
  endfunction

  function automatic bit far_from_leader(input int eta, input int phi);
    int de, dp;
    de = eta - ev_lead_eta;
    dp = phi - ev_lead_phi;
    if (dp > PHI_PI) dp -= PHI_TWO_PI;
    else if (dp < -PHI_PI) dp += PHI_TWO_PI;
    return (de * de + dp * dp) > int'(cfg_thr);
  endfunction

  function automatic void sel_clear();
    ev_lead_idx = 0; ev_lead_pt = 0; ev_lead_eta = 0; ev_lead_phi = 0;
    ev_lead_found = 0; ev_sec_idx = 0; ev_sec_pt = 0; ev_sec_found = 0;
    ev_count = 0; ev_over = 0;
  endfunction

  // Advance the event by one transfer; returns 1 when a result is due
  function automatic bit sel_advance(input cand_item_t c, output result_t r);
    int unsigned pt;
    r = '0;
    if (c.empty) begin
      sel_clear();
      return 1'b1;
    end
    if (ev_count >= MAX_CANDIDATES) begin
      ev_over = 1'b1;
    end else begin
      pt = cfg_src ? curv_pt(c.curv) : {16'd0, c.pt};
      if (pt > ev_lead_pt) begin
        // old leader drops to second only when far from the newcomer
        if (ev_lead_found && far_from_leader(int'(c.eta), int'(c.phi))) begin
          ev_sec_idx   = ev_lead_idx;
          ev_sec_pt    = ev_lead_pt;
          ev_sec_found = 1'b1;
        end
        ev_lead_idx   = ev_count;
        ev_lead_pt    = pt;
        ev_lead_eta   = int'(c.eta);
        ev_lead_phi   = int'(c.phi);
        ev_lead_found = 1'b1;
      end else if (pt > ev_sec_pt && far_from_leader(int'(c.eta), int'(c.phi))) begin
        ev_sec_idx   = ev_count;
        ev_sec_pt    = pt;
        ev_sec_found = 1'b1;
      end
      ev_count++;
    end
    if (!c.last) return 1'b0;
    if (ev_count == 1) begin
      r.first_valid = 1'b1;
    end else begin
      r.first_valid  = ev_lead_found;
      r.first_index  = ev_lead_found ? ev_lead_idx[IDXW-1:0] : '0;
      r.second_valid = ev_sec_found;
      r.second_index = ev_sec_found ? ev_sec_idx[IDXW-1:0] : '0;
    end
    r.overflow = ev_over;
    sel_clear();
    return 1'b1;
  endfunction

  function automatic result_t sel_res(input int fi, input bit fv, input int si, input bit sv,
                                      input bit ov);
    result_t r;
    r.first_index  = fi[IDXW-1:0];
    r.first_valid  = fv;
    r.second_index = si[IDXW-1:0];
    r.second_valid = sv;
    r.overflow     = ov;
    return r;
  endfunction

  function automatic stim_row_t row_c(input int pt, input int curv, input int eta, input int phi,
                                      input bit last, input bit empty, input int reps,
                                      input bit typed, input result_t res);
    stim_row_t r;
    r.kind       = ROW_CAND;
    r.item.pt    = pt[PTW-1:0];
    r.item.curv  = curv[CURVW-1:0];
    r.item.eta   = eta[ANGW-1:0];
    r.item.phi   = phi[ANGW-1:0];
    r.item.last  = last;
    r.item.empty = empty;
    r.reps       = reps;
    r.typed      = typed;
    r.res        = res;
    r.reg_idx    = CFG_PT_SOURCE;
    r.reg_val    = '0;
    return r;
  endfunction

  function automatic stim_row_t row_reg(input cfg_idx_e idx, input int val);
    stim_row_t r;
    r         = row_c(0, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0, '0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val[THRW-1:0];
    return r;
  endfunction

  function automatic cand_item_t draw_candidate();
    cand_item_t  c;
    int          v, e, p;
    int unsigned u;
    case ($urandom_range(0, 7))
      0:       u = 0;
      1:       u = 16'hFFFF;
      2:       u = $urandom_range(1, 15);
      3:       u = $urandom_range(0, 3) * 100;
      4:       u = $urandom_range(0, 65535);
      default: u = $urandom_range(0, 2000);
    endcase
    c.pt = u[PTW-1:0];
    case ($urandom_range(0, 7))
      0:       v = CURV_OFFSET;
      1:       v = -4096;
      2:       v = 4095;
      3:       v = CURV_OFFSET + int'($urandom_range(0, 20)) - 10;
      4:       v = int'($urandom_range(0, 4000)) - 2000;
      default: v = int'($urandom_range(0, 8191)) - 4096;
    endcase
    c.curv = v[CURVW-1:0];
    case ($urandom_range(0, 5))
      0:       e = ($urandom_range(0, 1) != 0) ? 768 : -768;
      1, 2:    e = int'($urandom_range(0, 1536)) - 768;
      default: e = base_eta + int'($urandom_range(0, 80)) - 40;
    endcase
    if (e > 768) e = 768;
    if (e < -768) e = -768;
    c.eta = e[ANGW-1:0];
    case ($urandom_range(0, 5))
      0:       p = ($urandom_range(0, 1) != 0) ? PHI_PI : -PHI_PI;
      1, 2:    p = int'($urandom_range(0, 2 * PHI_PI)) - PHI_PI;
      default: p = base_phi + int'($urandom_range(0, 80)) - 40;
    endcase
    if (p > PHI_PI) p -= PHI_TWO_PI;
    if (p < -PHI_PI) p += PHI_TWO_PI;
    c.phi   = p[ANGW-1:0];
    c.last  = 1'b0;
    c.empty = 1'b0;
    return c;
  endfunction

  task automatic send_item(input cand_item_t c, input bit allow_gap, input bit typed,
                           input result_t typed_res);
    result_t r;
    if (allow_gap && idle_en && $urandom_range(0, 5) == 0) begin
      cand_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    cand_valid_i     <= 1'b1;
    cand_pt_i        <= c.pt;
    curvature_i      <= c.curv;
    cand_eta_i       <= c.eta;
    cand_phi_i       <= c.phi;
    last_candidate_i <= c.last;
    empty_event_i    <= c.empty;
    do @(posedge clk_i); while (cand_stall_o);
    n_transfers++;
    if (sel_advance(c, r)) sel_expected_q.push_back(typed ? typed_res : r);
  endtask

  // Registers change only with the pipeline empty
  task automatic write_reg(input cfg_idx_e idx, input logic [THRW-1:0] val);
    cand_valid_i <= 1'b0;
    while (sel_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PT_SOURCE) cfg_src = val[0];
    else cfg_thr = val;
    n_reg_writes++;
  endtask

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        res_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        res_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        res_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : chk_res
    result_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (sel_expected_q.size() == 0) begin
        $error("result transfer with no event pending");
        n_fail++;
      end else begin
        want = sel_expected_q.pop_front();
        n_checked++;
        if (second_valid_o) n_second++;
        if (overflow_o) n_overflow++;
        if (first_index_o !== want.first_index) begin
          $error("first_index: expected %0d, got %0d", want.first_index, first_index_o);
          n_fail++;
        end
        if (first_valid_o !== want.first_valid) begin
          $error("first_valid: expected %0d, got %0d", want.first_valid, first_valid_o);
          n_fail++;
        end
        if (second_index_o !== want.second_index) begin
          $error("second_index: expected %0d, got %0d", want.second_index, second_index_o);
          n_fail++;
        end
        if (second_valid_o !== want.second_valid) begin
          $error("second_valid: expected %0d, got %0d", want.second_valid, second_valid_o);
          n_fail++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, overflow_o);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               sel_expected_q.size());
      $display("** leading_pair_select_separated_top: FAILED **");
      $finish;
    end
  end

  initial begin
    cand_item_t      c;
    logic [THRW-1:0] thr;
    int              items, len, kind;
    bit              brk;
    sel_clear();

    // after reset: pt from curvature, threshold 5898
    dir_table.push_back(row_c(0, 0, 0, 0, 1, 1, 1, 1, sel_res(0, 0, 0, 0, 0)));
    dir_table.push_back(row_c(0, 0, 0, 0, 1, 0, 1, 1, sel_res(0, 1, 0, 0, 0)));
    dir_table.push_back(row_c(0, -4096, -768, -804, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(0, 4095, 768, 804, 1, 0, 1, 0, '0));
    dir_table.push_back(row_c(0, 9, 0, 0, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(0, 10, 0, 100, 1, 0, 1, 0, '0));
    dir_table.push_back(row_reg(CFG_PT_SOURCE, 0));
    // all-zero pt event, then a lone zero-pt candidate
    dir_table.push_back(row_c(0, 0, 0, 0, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(0, 0, 0, 0, 1, 0, 1, 1, sel_res(0, 0, 0, 0, 0)));
    dir_table.push_back(row_c(0, 0, 0, 0, 1, 0, 1, 1, sel_res(0, 1, 0, 0, 0)));
    dir_table.push_back(row_c(65535, 0, -768, -804, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(1, 0, 768, 804, 1, 0, 1, 1, sel_res(0, 1, 1, 1, 0)));
    // phi wrap across pi
    dir_table.push_back(row_c(100, 0, 0, 800, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(200, 0, 0, -800, 1, 0, 1, 0, '0));
    dir_table.push_back(row_c(10, 0, 0, 0, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(20, 0, 300, 0, 1, 0, 1, 0, '0));
    // partial event dropped by an empty marker
    dir_table.push_back(row_c(5, 0, 0, 0, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(65535, -1, -1, -1, 1, 1, 1, 1, sel_res(0, 0, 0, 0, 0)));
    // more candidates than the event holds
    dir_table.push_back(row_c(7, 0, 0, 0, 0, 0, 17, 0, '0));
    dir_table.push_back(row_c(9, 0, 0, 0, 1, 0, 1, 1, sel_res(0, 1, 0, 0, 1)));
    dir_table.push_back(row_reg(CFG_SEP_THRESH, 0));
    dir_table.push_back(row_c(50, 0, 0, 0, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(40, 0, 1, 0, 1, 0, 1, 0, '0));
    dir_table.push_back(row_reg(CFG_SEP_THRESH, 65535));
    dir_table.push_back(row_c(50, 0, 0, 0, 0, 0, 1, 0, '0));
    dir_table.push_back(row_c(40, 0, 200, 100, 1, 0, 1, 0, '0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_REG) begin
        write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
      end else begin
        repeat (dir_table[i].reps) send_item(dir_table[i].item, 1'b1, dir_table[i].typed,
                                             dir_table[i].res);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       thr = 16'd5898;
        1, 3:    thr = '0;
        2, 4:    thr = 16'hFFFF;
        default: thr = THRW'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_PT_SOURCE, (ph == 0 || ph == 3 || ph == 4) ? 16'd1 : 16'd0);
      write_reg(CFG_SEP_THRESH, thr);
      if (ph == 5) idle_en = 1'b0;
      items = 0;
      if (ph == 2) begin
        // hold the result side and keep offering one-candidate events to fill the queue
        hold_req = 1'b1;
        repeat (60) begin
          c      = draw_candidate();
          c.last = 1'b1;
          send_item(c, 1'b0, 1'b0, '0);
          items++;
        end
      end
      while (items < PHASE_ITEMS) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          c       = draw_candidate();
          c.empty = 1'b1;
          c.last  = 1'($urandom_range(0, 1));
          send_item(c, 1'b1, 1'b0, '0);
          items++;
        end else begin
          len      = (kind == 1) ? $urandom_range(17, 20) : $urandom_range(1, 6);
          brk      = (kind == 2);
          base_eta = int'($urandom_range(0, 1536)) - 768;
          base_phi = ($urandom_range(0, 3) == 0) ? PHI_PI - 10
                                                 : int'($urandom_range(0, 1608)) - PHI_PI;
          for (int p = 0; p < len; p++) begin
            c       = draw_candidate();
            c.last  = (p == len - 1) && !brk;
            c.empty = (p == len - 1) && brk;
            send_item(c, 1'b1, 1'b0, '0);
            if (p < MAX_CANDIDATES) items++;
          end
        end
      end
    end

    cand_valid_i <= 1'b0;
    while (sel_expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d candidate transfers, %0d event results checked",
             n_transfers, n_checked);
    $display("(%0d with a second, %0d overflowed) over %0d register writes.",
             n_second, n_overflow, n_reg_writes);
    if (n_fail == 0) begin
      $display("** leading_pair_select_separated_top: PASSED **");
    end else begin
      $display("** leading_pair_select_separated_top: FAILED **");
    end
    $finish;
  end

endmodule
